>>> design/sidwc_pkg.sv
`default_nettype none
package sidwc_pkg;

    typedef enum logic [3:0] {
        MODE_ABS    = 4'd0,
        MODE_DIV    = 4'd1,
        MODE_AND    = 4'd2,
        MODE_OR     = 4'd3,
        MODE_XOR    = 4'd4,
        MODE_NOT    = 4'd5,
        MODE_SHL    = 4'd6,
        MODE_SAR    = 4'd7,
        MODE_MAX    = 4'd8,
        MODE_MIN    = 4'd9,
        MODE_MAXINT = 4'd10,
        MODE_MININT = 4'd11
    } t_mode;

    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } t_back_state;

    typedef struct packed {
        logic [3:0]         mode;
        logic signed [63:0] operand_a;
        logic signed [63:0] operand_b;
    } t_in;

    typedef struct packed {
        logic signed [63:0] value;
        logic signed [63:0] remainder;
        logic               divide_by_zero;
    } t_out;

    // Queue entry: the command word plus its class, settled at the front.
    typedef struct packed {
        t_in  cmd;
        logic is_div;
    } t_entry;

endpackage
`default_nettype wire

>>> design/sidwc_front.sv
`default_nettype none
module sidwc_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  sidwc_pkg::t_in        i_cmd,
    output logic                  o_busy,
    output logic                  o_head_valid,
    output sidwc_pkg::t_entry     o_head,
    input  wire                   i_pop
);
    import sidwc_pkg::*;

    t_entry     r_q [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    t_entry     entry;

    assign o_busy       = (r_count == 2'd2);
    assign push         = i_start && !o_busy;
    assign o_head_valid = (r_count != 2'd0);
    assign o_head       = r_q[r_rd_ptr];

    always_comb begin
        entry.cmd    = i_cmd;
        entry.is_div = (i_cmd.mode == MODE_DIV);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, i_pop};
        end
    end

endmodule
`default_nettype wire

>>> design/sidwc_back.sv
`default_nettype none
module sidwc_back #(
    parameter int DATA_WIDTH = 64
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_head_valid,
    input  sidwc_pkg::t_entry     i_head,
    output logic                  o_pop,
    output logic                  o_done,
    output sidwc_pkg::t_out       o_result
);
    import sidwc_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int CW = $clog2(DATA_WIDTH + 1);

    t_back_state   r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [W-1:0]  r_rem, n_rem, r_quo, n_quo, r_dvs, n_dvs;
    logic          r_neg_q, n_neg_q, r_neg_r, n_neg_r;
    logic          r_done, n_done;
    t_out          r_out, n_out;

    logic signed [W-1:0] a_w, b_w, fast_val;
    logic [5:0]          sh;
    logic [W:0]          partial, diff;
    logic [W-1:0]        step_rem, step_quo, q_fix, r_fix;

    assign a_w = i_head.cmd.operand_a[W-1:0];
    assign b_w = i_head.cmd.operand_b[W-1:0];
    assign sh  = i_head.cmd.operand_b[5:0];

    // Non-divide operations, computed combinationally.
    always_comb begin
        case (t_mode'(i_head.cmd.mode))
            MODE_ABS:    fast_val = a_w[W-1] ? -a_w : a_w;
            MODE_AND:    fast_val = a_w & b_w;
            MODE_OR:     fast_val = a_w | b_w;
            MODE_XOR:    fast_val = a_w ^ b_w;
            MODE_NOT:    fast_val = ~a_w;
            MODE_SHL:    fast_val = a_w << sh;
            MODE_SAR:    fast_val = a_w >>> sh;
            MODE_MAX:    fast_val = (a_w < b_w) ? b_w : a_w;
            MODE_MIN:    fast_val = (b_w < a_w) ? b_w : a_w;
            MODE_MAXINT: fast_val = {1'b0, {(W-1){1'b1}}};
            MODE_MININT: fast_val = {1'b1, {(W-1){1'b0}}};
            default:     fast_val = '0;
        endcase
    end

    // One restoring divide step per cycle.
    always_comb begin
        partial = {r_rem, r_quo[W-1]};
        diff    = partial - {1'b0, r_dvs};
        if (!diff[W]) begin
            step_rem = diff[W-1:0];
            step_quo = {r_quo[W-2:0], 1'b1};
        end else begin
            step_rem = partial[W-1:0];
            step_quo = {r_quo[W-2:0], 1'b0};
        end
        q_fix = r_neg_q ? -step_quo : step_quo;
        r_fix = r_neg_r ? -step_rem : step_rem;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dvs   = r_dvs;
        n_neg_q = r_neg_q;
        n_neg_r = r_neg_r;
        n_done  = 1'b0;
        n_out   = r_out;
        o_pop   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_head_valid) begin
                    o_pop = 1'b1;
                    if (i_head.is_div && b_w != '0) begin
                        n_state = ST_DIV;
                        n_cnt   = CW'(W);
                        n_rem   = '0;
                        n_quo   = a_w[W-1] ? -a_w : a_w;
                        n_dvs   = b_w[W-1] ? -b_w : b_w;
                        n_neg_q = a_w[W-1] ^ b_w[W-1];
                        n_neg_r = a_w[W-1];
                    end else begin
                        n_done                = 1'b1;
                        n_out.divide_by_zero  = i_head.is_div;
                        n_out.remainder       = '0;
                        n_out.value           = i_head.is_div ? '0 : 64'(fast_val);
                    end
                end
            end
            ST_DIV: begin
                n_rem = step_rem;
                n_quo = step_quo;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    n_state              = ST_IDLE;
                    n_done               = 1'b1;
                    n_out.value          = 64'($signed(q_fix));
                    n_out.remainder      = 64'($signed(r_fix));
                    n_out.divide_by_zero = 1'b0;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_dvs   <= n_dvs;
        r_neg_q <= n_neg_q;
        r_neg_r <= n_neg_r;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_out;

`ifndef ASSERT_OFF
    a_div_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_cnt != '0)
        else $error("divide active with zero step count");
    a_no_pop_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> !o_pop)
        else $error("queue popped while divide busy");
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && r_out.divide_by_zero |-> r_out.value == '0 && r_out.remainder == '0)
        else $error("divide by zero with nonzero result");
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE && $past(r_state) == ST_DIV && $past(i_rst_n) |-> r_done)
        else $error("divide finished without a result");
`endif

endmodule
`default_nettype wire

>>> design/signed_integer_alu_with_divide_core.sv
// Flow: words queue in the front; the back end pops one when idle and registers
//   its result to o_done; a nonzero divide first runs its restoring steps.
// Throughput: one word per cycle for non-divide ops while no divide holds the
//   back end; a divide holds it for its pop plus DATA_WIDTH restoring steps,
//   while the 2-entry queue keeps accepting until full.
// Reset: synchronous, active low; clears queue, back-end state and o_done.
// The receiver cannot stall: each result shows for one cycle with o_done.
`default_nettype none
module signed_integer_alu_with_divide_core #(
    parameter int DATA_WIDTH = 64
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    output logic              busy,
    input  sidwc_pkg::t_in    i_cmd,
    output logic              o_done,
    output sidwc_pkg::t_out   o_result
);
    import sidwc_pkg::*;

    logic   head_valid;
    logic   pop;
    t_entry head;

    // Front: take command words and classify divide vs. non-divide ops.
    sidwc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_cmd        (i_cmd),
        .o_busy       (busy),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    // Back: execute in order; divide iterates in place.
    sidwc_back #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_done       (o_done),
        .o_result     (o_result)
    );

endmodule
`default_nettype wire
